// ===== rtl/core/ssh_pkg.sv =====
// Package for the space-saving heavy-hitter unit: sizes, command codes,
// the search token that travels along the cell chain, and the entry write bus.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ssh_pkg;

  localparam int unsigned TableEntries  = 16;
  localparam int unsigned KeyBits       = 64;
  localparam int unsigned CountBits     = 32;

  localparam int unsigned KeyPortBits   = 64;
  localparam int unsigned CountPortBits = 32;
  localparam int unsigned SlotBits      = 4;

  localparam int unsigned IdxBits    = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int unsigned FillBits   = $clog2(TableEntries + 1);
  localparam int unsigned SelCmpBits = (IdxBits > SlotBits) ? IdxBits : SlotBits;

  typedef logic [IdxBits-1:0]   idx_t;
  typedef logic [FillBits-1:0]  fill_t;
  typedef logic [KeyBits-1:0]   key_t;
  typedef logic [CountBits-1:0] cnt_t;
  typedef logic [SlotBits-1:0]  sel_t;

  typedef enum logic {
    CmdObserve = 1'b0,
    CmdRead    = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
    key_t key;
    sel_t sel;
    logic found;
    idx_t tgt_idx;
    key_t tgt_key;
    cnt_t tgt_cnt;
    logic min_vld;
    idx_t min_idx;
    key_t min_key;
    cnt_t min_cnt;
  } tok_t;

  typedef struct packed {
    logic en;
    idx_t idx;
    key_t key;
    cnt_t cnt;
  } wr_t;

  function automatic cnt_t sat_inc(cnt_t c);
    cnt_t r;
    r = (c == {CountBits{1'b1}}) ? c : c + cnt_t'(1);
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/space_saving_heavy_hitters_unit.sv =====
// Space-saving heavy-hitter unit: one command at a time. A new input is taken
// only once the result of the previous command has been registered at the
// output. The search token walks the chain of TableEntries cells, one cell
// per cycle. Reset empties the table at once (fill level zero); no clearing
// pass is needed.
// Depends on ssh_pkg, ssh_cell and ssh_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module space_saving_heavy_hitters_unit import ssh_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic                     command_i,
  input  wire logic [KeyPortBits-1:0]   key_i,
  input  wire logic [SlotBits-1:0]      slot_select_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [SlotBits-1:0]           slot_o,
  output logic [KeyPortBits-1:0]        entry_key_o,
  output logic [CountPortBits-1:0]      entry_count_o,
  output logic                          entry_valid_o,
  output logic                          was_hit_o,
  output logic                          replaced_o,
  output logic [KeyPortBits-1:0]        evicted_key_o,
  output logic [CountPortBits-1:0]      evicted_count_o
);

  logic  chain_vld [TableEntries+1];
  tok_t  chain_tok [TableEntries+1];
  fill_t fill;
  wr_t   wr;

  ssh_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .command_i       (command_i),
    .key_i           (key_i),
    .slot_select_i   (slot_select_i),
    .launch_vld_o    (chain_vld[0]),
    .launch_tok_o    (chain_tok[0]),
    .last_vld_i      (chain_vld[TableEntries]),
    .last_tok_i      (chain_tok[TableEntries]),
    .fill_o          (fill),
    .wr_o            (wr),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .slot_o          (slot_o),
    .entry_key_o     (entry_key_o),
    .entry_count_o   (entry_count_o),
    .entry_valid_o   (entry_valid_o),
    .was_hit_o       (was_hit_o),
    .replaced_o      (replaced_o),
    .evicted_key_o   (evicted_key_o),
    .evicted_count_o (evicted_count_o)
  );

  for (genvar i = 0; i < TableEntries; i++) begin : g_cell
    ssh_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (IdxBits'(i)),
      .fill_i (fill),
      .wr_i   (wr),
      .vld_i  (chain_vld[i]),
      .tok_i  (chain_tok[i]),
      .vld_o  (chain_vld[i+1]),
      .tok_o  (chain_tok[i+1])
    );
  end

endmodule

`default_nettype wire

// ===== rtl/core/ssh_cell.sv =====
// One table slot of the heavy-hitter unit: holds a key and a count, updates
// the passing search token and hands it to the next cell. Depends on ssh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssh_cell import ssh_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire idx_t idx_i,
  input  wire fill_t fill_i,
  input  wire wr_t  wr_i,
  input  wire logic vld_i,
  input  wire tok_t tok_i,
  output logic      vld_o,
  output tok_t      tok_o
);

  key_t key_q;
  cnt_t cnt_q;
  logic vld_q;
  tok_t tok_q, tok_d;
  logic occ, sel_hit;

  assign occ     = FillBits'(idx_i) < fill_i;
  assign sel_hit = SelCmpBits'(tok_i.sel) == SelCmpBits'(idx_i);

  always_comb begin
    tok_d = tok_i;
    if (occ) begin
      unique case (tok_i.cmd)
        CmdObserve: begin
          if (!tok_i.found && (tok_i.key == key_q)) begin
            tok_d.found   = 1'b1;
            tok_d.tgt_idx = idx_i;
            tok_d.tgt_key = key_q;
            tok_d.tgt_cnt = cnt_q;
          end
          if (!tok_i.min_vld || (cnt_q < tok_i.min_cnt)) begin
            tok_d.min_vld = 1'b1;
            tok_d.min_idx = idx_i;
            tok_d.min_key = key_q;
            tok_d.min_cnt = cnt_q;
          end
        end
        CmdRead: begin
          if (sel_hit) begin
            tok_d.found   = 1'b1;
            tok_d.tgt_idx = idx_i;
            tok_d.tgt_key = key_q;
            tok_d.tgt_cnt = cnt_q;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
    if (wr_i.en && (wr_i.idx == idx_i)) begin
      key_q <= wr_i.key;
      cnt_q <= wr_i.cnt;
    end
  end

  assign vld_o = vld_q;
  assign tok_o = tok_q;

endmodule

`default_nettype wire

// ===== rtl/core/ssh_ctrl.sv =====
// Sequencer of the heavy-hitter unit: accepts commands, launches the search
// token, decides the table update and holds the result. Depends on ssh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssh_ctrl import ssh_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic                     command_i,
  input  wire logic [KeyPortBits-1:0]   key_i,
  input  wire logic [SlotBits-1:0]      slot_select_i,
  output logic                          launch_vld_o,
  output tok_t                          launch_tok_o,
  input  wire logic                     last_vld_i,
  input  wire tok_t                     last_tok_i,
  output fill_t                         fill_o,
  output wr_t                           wr_o,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [SlotBits-1:0]           slot_o,
  output logic [KeyPortBits-1:0]        entry_key_o,
  output logic [CountPortBits-1:0]      entry_count_o,
  output logic                          entry_valid_o,
  output logic                          was_hit_o,
  output logic                          replaced_o,
  output logic [KeyPortBits-1:0]        evicted_key_o,
  output logic [CountPortBits-1:0]      evicted_count_o
);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StScan = 3'b010,
    StDone = 3'b100
  } state_e;

  state_e state_q, state_d;
  fill_t  fill_q, fill_d;
  logic   launch_vld_q;
  tok_t   launch_tok_q, launch_tok_d, fin_q;
  logic   out_valid_q, out_valid_d;
  logic   accept, fire;

  idx_t res_idx;
  key_t res_key;
  cnt_t res_cnt;
  logic res_valid, res_hit, res_repl;
  key_t res_evk;
  cnt_t res_evc;

  logic [SlotBits-1:0]      slot_q;
  logic [KeyPortBits-1:0]   entry_key_q, evicted_key_q;
  logic [CountPortBits-1:0] entry_count_q, evicted_count_q;
  logic                     entry_valid_q, was_hit_q, replaced_q;

  assign in_ready_o = state_q == StIdle;
  assign accept     = in_valid_i && in_ready_o;
  assign fire       = (state_q == StDone) && (!out_valid_q || out_ready_i);

  always_comb begin
    launch_tok_d     = '0;
    launch_tok_d.cmd = cmd_e'(command_i);
    launch_tok_d.key = key_i[KeyBits-1:0];
    launch_tok_d.sel = slot_select_i;
  end

  always_comb begin
    res_idx   = fin_q.tgt_idx;
    res_key   = fin_q.tgt_key;
    res_cnt   = fin_q.tgt_cnt;
    res_valid = 1'b1;
    res_hit   = 1'b0;
    res_repl  = 1'b0;
    res_evk   = '0;
    res_evc   = '0;
    wr_o      = '0;
    fill_d    = fill_q;
    unique case (fin_q.cmd)
      CmdRead: begin
        res_idx   = IdxBits'(fin_q.sel);
        res_valid = fin_q.found;
        if (!fin_q.found) begin
          res_key = '0;
          res_cnt = '0;
        end
      end
      CmdObserve: begin
        if (fin_q.found) begin
          res_hit = 1'b1;
          res_cnt = sat_inc(fin_q.tgt_cnt);
        end else if (fill_q < FillBits'(TableEntries)) begin
          res_idx = IdxBits'(fill_q);
          res_key = fin_q.key;
          res_cnt = cnt_t'(1);
          fill_d  = fill_q + fill_t'(1);
        end else begin
          res_idx  = fin_q.min_idx;
          res_key  = fin_q.key;
          res_cnt  = sat_inc(fin_q.min_cnt);
          res_repl = 1'b1;
          res_evk  = fin_q.min_key;
          res_evc  = fin_q.min_cnt;
        end
        wr_o.en  = fire;
        wr_o.idx = res_idx;
        wr_o.key = res_key;
        wr_o.cnt = res_cnt;
      end
      default: ;
    endcase
    if (!fire) begin
      fill_d = fill_q;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (accept) state_d = StScan;
      StScan: if (last_vld_i) state_d = StDone;
      StDone: if (fire) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (fire) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      fill_q       <= '0;
      launch_vld_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      fill_q       <= fill_d;
      launch_vld_q <= accept;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      launch_tok_q <= launch_tok_d;
    end
    if ((state_q == StScan) && last_vld_i) begin
      fin_q <= last_tok_i;
    end
    if (fire) begin
      slot_q          <= SlotBits'(res_idx);
      entry_key_q     <= KeyPortBits'(res_key);
      entry_count_q   <= CountPortBits'(res_cnt);
      entry_valid_q   <= res_valid;
      was_hit_q       <= res_hit;
      replaced_q      <= res_repl;
      evicted_key_q   <= KeyPortBits'(res_evk);
      evicted_count_q <= CountPortBits'(res_evc);
    end
  end

  assign launch_vld_o    = launch_vld_q;
  assign launch_tok_o    = launch_tok_q;
  assign fill_o          = fill_q;
  assign out_valid_o     = out_valid_q;
  assign slot_o          = slot_q;
  assign entry_key_o     = entry_key_q;
  assign entry_count_o   = entry_count_q;
  assign entry_valid_o   = entry_valid_q;
  assign was_hit_o       = was_hit_q;
  assign replaced_o      = replaced_q;
  assign evicted_key_o   = evicted_key_q;
  assign evicted_count_o = evicted_count_q;

endmodule

`default_nettype wire

// ===== rtl/core/ssh_checker.sv =====
// Port-level checks for the space-saving heavy-hitter unit, attached to the
// top level by a bind statement. Depends on ssh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssh_checker import ssh_pkg::*; (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     in_valid_i,
  input wire logic                     in_ready_o,
  input wire logic                     command_i,
  input wire logic [KeyPortBits-1:0]   key_i,
  input wire logic [SlotBits-1:0]      slot_select_i,
  input wire logic                     out_valid_o,
  input wire logic                     out_ready_i,
  input wire logic [SlotBits-1:0]      slot_o,
  input wire logic [KeyPortBits-1:0]   entry_key_o,
  input wire logic [CountPortBits-1:0] entry_count_o,
  input wire logic                     entry_valid_o,
  input wire logic                     was_hit_o,
  input wire logic                     replaced_o,
  input wire logic [KeyPortBits-1:0]   evicted_key_o,
  input wire logic [CountPortBits-1:0] evicted_count_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(entry_key_o)
      && $stable(entry_count_o) && $stable(slot_o))
    else $error("result changed while stalled");

  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a command is in progress");

  a_no_evict_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !replaced_o |-> evicted_key_o == '0 && evicted_count_o == '0)
    else $error("eviction fields set without an eviction");

  a_evict_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && replaced_o |-> entry_valid_o && !was_hit_o && entry_count_o != '0)
    else $error("eviction result inconsistent");

  a_read_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !entry_valid_o |-> !was_hit_o && !replaced_o
      && entry_key_o == '0 && entry_count_o == '0)
    else $error("empty slot result carries data");

endmodule

bind space_saving_heavy_hitters_unit ssh_checker u_ssh_checker (.*);

`default_nettype wire
